// ===== src/wavhp_pkg.sv =====
// Shared constants and types for the WAV header parser.
`timescale 1ns / 1ps

package wavhp_pkg;

  localparam logic [31:0] IdRiff     = 32'h4646_4952;
  localparam logic [31:0] IdWave     = 32'h4556_4157;
  localparam logic [31:0] IdFmt      = 32'h2074_6D66;
  localparam logic [31:0] IdData     = 32'h6174_6164;
  localparam logic [15:0] PcmFormat  = 16'd1;
  localparam logic [31:0] FmtBaseLen = 32'd16;

  localparam int DivW     = 32;
  localparam int DivSteps = DivW;
  localparam int CntW     = $clog2(DivSteps);

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StNoRiff    = 3'd1,
    StNoWave    = 3'd2,
    StNoFmt     = 3'd3,
    StNotPcm    = 3'd4,
    StEarlyEnd  = 3'd5,
    StZeroFrame = 3'd6
  } status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/wavhp_in_if.sv =====
// Byte stream channel into the WAV header parser.
`timescale 1ns / 1ps

interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;
  logic       stream_end;

  modport source (output valid, data_byte, file_start, stream_end, input ready);
  modport sink   (input valid, data_byte, file_start, stream_end, output ready);
endinterface

// ===== src/wavhp_out_if.sv =====
// Result channel out of the WAV header parser.
`timescale 1ns / 1ps

interface wavhp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] channel_count;
  logic [31:0] samp_rate;
  logic [15:0] sample_bits;
  logic [31:0] frame_count;
  logic [31:0] data_offset;

  modport source (output valid, status, channel_count, samp_rate, sample_bits,
                  frame_count, data_offset, input ready);
  modport sink   (input valid, status, channel_count, samp_rate, sample_bits,
                  frame_count, data_offset, output ready);
endinterface

// ===== src/wavhp_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module wavhp_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [wavhp_pkg::DivW-1:0] dividend,
  input  logic [wavhp_pkg::DivW-1:0] divisor,
  output wavhp_pkg::div_stat_t     stat,
  output logic [wavhp_pkg::DivW-1:0] quotient
);

  logic                          busy;
  logic                          done;
  logic [wavhp_pkg::CntW-1:0]    cnt;
  logic [wavhp_pkg::DivW-1:0]    rem;
  logic [wavhp_pkg::DivW-1:0]    quo;
  logic [wavhp_pkg::DivW-1:0]    dvs;
  logic [wavhp_pkg::DivW:0]      trial;
  logic [wavhp_pkg::DivW:0]      diff;
  logic                          ge;

  assign trial = {rem, quo[wavhp_pkg::DivW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= wavhp_pkg::CntW'(wavhp_pkg::DivSteps - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[wavhp_pkg::DivW-1:0] : trial[wavhp_pkg::DivW-1:0];
      quo <= {quo[wavhp_pkg::DivW-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

// ===== src/wav_header_parser.sv =====
// WAV header parser top level: byte sequencer, format capture and result register.
// Results: a result is valid the cycle after the byte that completes it; an ok result
//   is held back until the 32-step divider finishes and the frame count is registered.
// Throughput: one byte per cycle unless a result waits for result.ready; the data-size byte
//   stalls the input for the divider and result handoff when the frame size is nonzero.
// Reset: rst clears the phase to the RIFF check, the byte position and result valid.
`timescale 1ns / 1ps

module wav_header_parser (
  input  logic clk,
  input  logic rst,
  wavhp_in_if.sink    stream,
  wavhp_out_if.source result
);

  typedef enum logic [15:0] {
    PhRiff      = 16'h0001,
    PhFileSize  = 16'h0002,
    PhWave      = 16'h0004,
    PhFmt       = 16'h0008,
    PhFmtLen    = 16'h0010,
    PhFormat    = 16'h0020,
    PhChannels  = 16'h0040,
    PhRate      = 16'h0080,
    PhByteRate  = 16'h0100,
    PhAlign     = 16'h0200,
    PhBits      = 16'h0400,
    PhFmtSkip   = 16'h0800,
    PhChunkId   = 16'h1000,
    PhDataSize  = 16'h2000,
    PhOtherSize = 16'h4000,
    PhBodySkip  = 16'h8000
  } phase_t;

  phase_t      phase, phase_next, cur_phase;
  logic [1:0]  idx, idx_next, cur_idx;
  logic [31:0] gword, gword_next, gw_new, shifted;
  logic [31:0] fmt_length, fmt_next;
  logic [31:0] skip_rem, skip_next;
  logic [15:0] held_ch, ch_next;
  logic [31:0] held_rate, rate_next;
  logic [15:0] held_bits, bits_next;
  logic [28:0] frame_bytes, fb_next;
  logic [31:0] prod;
  logic [31:0] byte_pos, pos_next, cur_pos;
  logic        finished, fin_next, cur_fin;
  logic        done2, done4;
  logic        res_fire, div_go;
  wavhp_pkg::status_t res_status;

  logic        accept;
  logic        out_valid;
  wavhp_pkg::div_stat_t dstat;
  logic [31:0] quotient;

  logic [2:0]  out_status;
  logic [15:0] out_ch;
  logic [31:0] out_rate;
  logic [15:0] out_bits;
  logic [31:0] out_frames;
  logic [31:0] out_offset;

  assign stream.ready = !rst && !dstat.busy && !dstat.done && (!out_valid || result.ready);
  assign accept       = stream.valid && stream.ready;

  assign cur_phase = stream.file_start ? PhRiff : phase;
  assign cur_idx   = stream.file_start ? 2'd0 : idx;
  assign cur_pos   = stream.file_start ? 32'd0 : byte_pos;
  assign cur_fin   = stream.file_start ? 1'b0 : finished;

  assign shifted = {24'd0, stream.data_byte} << {cur_idx, 3'b000};
  assign gw_new  = (cur_idx == 2'd0) ? {24'd0, stream.data_byte} : (gword | shifted);
  assign done2   = cur_idx == 2'd1;
  assign done4   = cur_idx == 2'd3;
  assign prod    = {16'd0, held_ch} * {16'd0, gw_new[15:0]};

  always_comb begin
    phase_next = cur_phase;
    idx_next   = cur_idx;
    gword_next = gword;
    fmt_next   = fmt_length;
    skip_next  = skip_rem;
    ch_next    = held_ch;
    rate_next  = held_rate;
    bits_next  = held_bits;
    fb_next    = frame_bytes;
    pos_next   = cur_pos;
    fin_next   = cur_fin;
    res_fire   = 1'b0;
    res_status = wavhp_pkg::StOk;
    div_go     = 1'b0;
    if (!cur_fin) begin
      pos_next   = cur_pos + 32'd1;
      gword_next = gw_new;
      unique case (cur_phase)
        PhRiff: begin
          idx_next = cur_idx + 2'd1;
          if (done4) begin
            if (gw_new != wavhp_pkg::IdRiff) begin
              res_fire   = 1'b1;
              res_status = wavhp_pkg::StNoRiff;
            end else begin
              phase_next = PhFileSize;
            end
          end
        end
        PhFileSize: begin
          idx_next = cur_idx + 2'd1;
          if (done4) phase_next = PhWave;
        end
        PhWave: begin
          idx_next = cur_idx + 2'd1;
          if (done4) begin
            if (gw_new != wavhp_pkg::IdWave) begin
              res_fire   = 1'b1;
              res_status = wavhp_pkg::StNoWave;
            end else begin
              phase_next = PhFmt;
            end
          end
        end
        PhFmt: begin
          idx_next = cur_idx + 2'd1;
          if (done4) begin
            if (gw_new != wavhp_pkg::IdFmt) begin
              res_fire   = 1'b1;
              res_status = wavhp_pkg::StNoFmt;
            end else begin
              phase_next = PhFmtLen;
            end
          end
        end
        PhFmtLen: begin
          idx_next = cur_idx + 2'd1;
          if (done4) begin
            fmt_next   = gw_new;
            phase_next = PhFormat;
          end
        end
        PhFormat: begin
          idx_next = done2 ? 2'd0 : cur_idx + 2'd1;
          if (done2) begin
            if (gw_new[15:0] != wavhp_pkg::PcmFormat) begin
              res_fire   = 1'b1;
              res_status = wavhp_pkg::StNotPcm;
            end else begin
              phase_next = PhChannels;
            end
          end
        end
        PhChannels: begin
          idx_next = done2 ? 2'd0 : cur_idx + 2'd1;
          if (done2) begin
            ch_next    = gw_new[15:0];
            phase_next = PhRate;
          end
        end
        PhRate: begin
          idx_next = cur_idx + 2'd1;
          if (done4) begin
            rate_next  = gw_new;
            phase_next = PhByteRate;
          end
        end
        PhByteRate: begin
          idx_next = cur_idx + 2'd1;
          if (done4) phase_next = PhAlign;
        end
        PhAlign: begin
          idx_next = done2 ? 2'd0 : cur_idx + 2'd1;
          if (done2) phase_next = PhBits;
        end
        PhBits: begin
          idx_next = done2 ? 2'd0 : cur_idx + 2'd1;
          if (done2) begin
            bits_next = gw_new[15:0];
            fb_next   = prod[31:3];
            if (fmt_length > wavhp_pkg::FmtBaseLen) begin
              skip_next  = fmt_length - wavhp_pkg::FmtBaseLen;
              phase_next = PhFmtSkip;
            end else begin
              phase_next = PhChunkId;
            end
          end
        end
        PhFmtSkip, PhBodySkip: begin
          skip_next = skip_rem - 32'd1;
          if (skip_rem == 32'd1) phase_next = PhChunkId;
        end
        PhChunkId: begin
          idx_next = cur_idx + 2'd1;
          if (done4) phase_next = (gw_new == wavhp_pkg::IdData) ? PhDataSize : PhOtherSize;
        end
        PhDataSize: begin
          idx_next = cur_idx + 2'd1;
          if (done4) begin
            fin_next = 1'b1;
            if (frame_bytes == 29'd0) begin
              res_fire   = 1'b1;
              res_status = wavhp_pkg::StZeroFrame;
            end else begin
              div_go = 1'b1;
            end
          end
        end
        PhOtherSize: begin
          idx_next = cur_idx + 2'd1;
          if (done4) begin
            if (gw_new == 32'd0) begin
              phase_next = PhChunkId;
            end else begin
              skip_next  = gw_new;
              phase_next = PhBodySkip;
            end
          end
        end
        default: begin
          phase_next = PhRiff;
          idx_next   = 2'd0;
        end
      endcase
      if (!res_fire && !div_go && stream.stream_end) begin
        res_fire   = 1'b1;
        res_status = wavhp_pkg::StEarlyEnd;
      end
      if (res_fire) fin_next = 1'b1;
    end
  end

  wavhp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && div_go),
    .dividend (gw_new),
    .divisor  ({3'd0, frame_bytes}),
    .stat     (dstat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PhRiff;
      idx       <= 2'd0;
      byte_pos  <= 32'd0;
      finished  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase    <= phase_next;
        idx      <= idx_next;
        byte_pos <= pos_next;
        finished <= fin_next;
      end
      if (result.valid && result.ready) out_valid <= 1'b0;
      if (accept && res_fire) out_valid <= 1'b1;
      if (dstat.done) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gword       <= gword_next;
      fmt_length  <= fmt_next;
      skip_rem    <= skip_next;
      held_ch     <= ch_next;
      held_rate   <= rate_next;
      held_bits   <= bits_next;
      frame_bytes <= fb_next;
    end
    if (accept && (res_fire || div_go)) begin
      out_status <= res_status;
      out_frames <= 32'd0;
      if (res_status == wavhp_pkg::StOk || res_status == wavhp_pkg::StZeroFrame) begin
        out_ch     <= held_ch;
        out_rate   <= held_rate;
        out_bits   <= held_bits;
        out_offset <= pos_next;
      end else begin
        out_ch     <= 16'd0;
        out_rate   <= 32'd0;
        out_bits   <= 16'd0;
        out_offset <= 32'd0;
      end
    end
    if (dstat.done) out_frames <= quotient;
  end

  assign result.valid         = out_valid;
  assign result.status        = out_status;
  assign result.channel_count = out_ch;
  assign result.samp_rate     = out_rate;
  assign result.sample_bits   = out_bits;
  assign result.frame_count   = out_frames;
  assign result.data_offset   = out_offset;

endmodule

// ===== test/wavhp_header_checker.sv =====
// Header checker: predicts parser results from the accepted byte beats and compares them.
`timescale 1ns / 1ps

module wavhp_header_checker
  import wavhp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  wavhp_in_if  stream,
  wavhp_out_if result,
  output int   fail_count,
  output int   pending
);

  typedef enum logic [3:0] {
    PhRiff, PhFileSize, PhWave, PhFmtId, PhFmtLen, PhFormat, PhChannels, PhRate,
    PhByteRate, PhAlign, PhBits, PhFmtSkip, PhChunkId, PhDataSize, PhOtherSize, PhBodySkip
  } parse_phase_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] frames;
    logic [31:0] offset;
  } header_result_t;

  parse_phase_t   phase;
  logic [1:0]     lane;
  logic [31:0]    word;
  logic [31:0]    fmt_len;
  logic [31:0]    skip_left;
  logic [15:0]    channels;
  logic [31:0]    rate;
  logic [15:0]    bits;
  logic [31:0]    position;
  bit             header_done;
  header_result_t expected_headers[$];
  int             mismatches;
  int             headers_got;

  task automatic clear_parser();
    phase       = PhRiff;
    lane        = '0;
    word        = '0;
    fmt_len     = '0;
    skip_left   = '0;
    channels    = '0;
    rate        = '0;
    bits        = '0;
    position    = '0;
    header_done = 1'b0;
  endtask

  // Little-endian field assembly; true once n bytes are in.
  function automatic bit take_byte(input logic [7:0] b, input int n);
    if (lane == 2'd0) word = 32'(b);
    else word = word | (32'(b) << (8 * lane));
    if (int'(lane) + 1 >= n) begin
      lane = '0;
      return 1'b1;
    end
    lane = lane + 2'd1;
    return 1'b0;
  endfunction

  task automatic predict_header(input logic [7:0] b, input bit first, input bit last);
    header_result_t r;
    logic [31:0]    frame_bytes;
    bit             emit;
    if (first) clear_parser();
    if (header_done) return;
    r = '0;
    emit = 1'b0;
    position = position + 32'd1;
    case (phase)
      PhRiff: if (take_byte(b, 4)) begin
        if (word != IdRiff) begin
          r.status = StNoRiff;
          emit = 1'b1;
        end else phase = PhFileSize;
      end
      PhFileSize: if (take_byte(b, 4)) phase = PhWave;
      PhWave: if (take_byte(b, 4)) begin
        if (word != IdWave) begin
          r.status = StNoWave;
          emit = 1'b1;
        end else phase = PhFmtId;
      end
      PhFmtId: if (take_byte(b, 4)) begin
        if (word != IdFmt) begin
          r.status = StNoFmt;
          emit = 1'b1;
        end else phase = PhFmtLen;
      end
      PhFmtLen: if (take_byte(b, 4)) begin
        fmt_len = word;
        phase = PhFormat;
      end
      PhFormat: if (take_byte(b, 2)) begin
        if (word != 32'(PcmFormat)) begin
          r.status = StNotPcm;
          emit = 1'b1;
        end else phase = PhChannels;
      end
      PhChannels: if (take_byte(b, 2)) begin
        channels = word[15:0];
        phase = PhRate;
      end
      PhRate: if (take_byte(b, 4)) begin
        rate = word;
        phase = PhByteRate;
      end
      PhByteRate: if (take_byte(b, 4)) phase = PhAlign;
      PhAlign: if (take_byte(b, 2)) phase = PhBits;
      PhBits: if (take_byte(b, 2)) begin
        bits = word[15:0];
        if (fmt_len > FmtBaseLen) begin
          skip_left = fmt_len - FmtBaseLen;
          phase = PhFmtSkip;
        end else phase = PhChunkId;
      end
      PhChunkId: if (take_byte(b, 4)) phase = (word == IdData) ? PhDataSize : PhOtherSize;
      PhDataSize: if (take_byte(b, 4)) begin
        frame_bytes = ({16'd0, channels} * {16'd0, bits}) >> 3;
        r.channels = channels;
        r.rate     = rate;
        r.bits     = bits;
        r.offset   = position;
        emit = 1'b1;
        if (frame_bytes == 32'd0) r.status = StZeroFrame;
        else begin
          r.status = StOk;
          r.frames = word / frame_bytes;
        end
      end
      PhOtherSize: if (take_byte(b, 4)) begin
        if (word == 32'd0) phase = PhChunkId;
        else begin
          skip_left = word;
          phase = PhBodySkip;
        end
      end
      default: begin
        // fmt extension and chunk bodies are skipped the same way
        skip_left = skip_left - 32'd1;
        if (skip_left == 32'd0) phase = PhChunkId;
      end
    endcase
    if (!emit && last) begin
      r = '0;
      r.status = StEarlyEnd;
      emit = 1'b1;
    end
    if (emit) begin
      header_done = 1'b1;
      expected_headers.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    header_result_t want;
    if (rst) begin
      clear_parser();
      expected_headers.delete();
    end else begin
      if (stream.valid && stream.ready)
        predict_header(stream.data_byte, stream.file_start, stream.stream_end);
      if (result.valid && result.ready) begin
        headers_got++;
        if (expected_headers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: st %0d ch %0d rate %0d bits %0d frames %0d off %0d",
                     result.status, result.channel_count, result.samp_rate,
                     result.sample_bits, result.frame_count, result.data_offset);
        end else begin
          want = expected_headers.pop_front();
          if (result.status !== want.status || result.channel_count !== want.channels ||
              result.samp_rate !== want.rate || result.sample_bits !== want.bits ||
              result.frame_count !== want.frames || result.data_offset !== want.offset) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result beat %0d expected: st %0d ch %0d rate %0d bits %0d frames %0d off %0d",
                       headers_got, want.status, want.channels, want.rate, want.bits,
                       want.frames, want.offset);
              $display("result beat %0d actual:   st %0d ch %0d rate %0d bits %0d frames %0d off %0d",
                       headers_got, result.status, result.channel_count, result.samp_rate,
                       result.sample_bits, result.frame_count, result.data_offset);
            end
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_headers.size();
  end

endmodule

// ===== test/tb_wav_header_parser.sv =====
// Testbench top for the WAV header parser: byte-stream stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_wav_header_parser;
  import wavhp_pkg::*;

  typedef enum int {
    StageDirected, StageFree, StageHold, StageSendIdle, StageRecvStall, StageBoth
  } stage_t;

  logic        clk = 1'b0;
  logic        rst;
  stage_t      stage = StageDirected;
  stage_t      prev_stage = StageDirected;
  int          hold_left;
  int          fail_count;
  int          pending;
  int          bytes_sent;
  logic [7:0]  file_bytes[$];
  bit          file_ends[$];

  wavhp_in_if  in_ch();
  wavhp_out_if out_ch();

  wav_header_parser i_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (in_ch),
    .result (out_ch)
  );

  wavhp_header_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .stream     (in_ch),
    .result     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int send_idle_pct(input stage_t s);
    case (s)
      StageSendIdle: return 79;
      StageBoth:     return 34;
      default:       return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(input stage_t s);
    case (s)
      StageRecvStall: return 79;
      StageBoth:      return 34;
      default:        return 0;
    endcase
  endfunction

  // Result side; entering the hold stage blocks results for a long stretch.
  always @(posedge clk) begin
    if (stage == StageHold && prev_stage != StageHold) hold_left = 300;
    prev_stage = stage;
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct(stage));
  end

  task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
    while ($urandom_range(99) < send_idle_pct(stage)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.file_start <= first;
    in_ch.stream_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic put8(input logic [7:0] b);
    file_bytes.push_back(b);
    file_ends.push_back(1'b0);
  endtask

  task automatic put16(input logic [15:0] v);
    put8(v[7:0]);
    put8(v[15:8]);
  endtask

  task automatic put32(input logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endtask

  task automatic send_file(input bit mark_start);
    foreach (file_bytes[i]) send_byte(file_bytes[i], mark_start && i == 0, file_ends[i]);
    file_bytes.delete();
    file_ends.delete();
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic build_wav();
    int unsigned fmt_len;
    int unsigned body;
    logic [15:0] chans;
    logic [15:0] width;
    logic [31:0] tag_word;
    file_bytes.delete();
    file_ends.delete();
    put32(IdRiff);
    put32($urandom);
    put32(IdWave);
    put32(IdFmt);
    case ($urandom_range(9))
      0, 1:    fmt_len = $urandom_range(15);
      2, 3:    fmt_len = $urandom_range(40, 17);
      default: fmt_len = 16;
    endcase
    put32(fmt_len);
    put16(($urandom_range(15) == 0) ? 16'($urandom) : PcmFormat);
    case ($urandom_range(7))
      0:       chans = 16'd0;
      1:       chans = 16'hFFFF;
      2:       chans = 16'($urandom);
      default: chans = 16'($urandom_range(8, 1));
    endcase
    case ($urandom_range(7))
      0:       width = 16'd0;
      1:       width = 16'($urandom_range(7, 1));
      2:       width = 16'hFFFF;
      3:       width = 16'($urandom);
      default: width = 16'(8 * $urandom_range(4, 1));
    endcase
    put16(chans);
    put32($urandom);
    put32($urandom);
    put16(16'($urandom));
    put16(width);
    repeat ((fmt_len > 16) ? fmt_len - 16 : 0) put8(8'($urandom));
    repeat ($urandom_range(2)) begin
      do tag_word = $urandom; while (tag_word == IdData);
      body = ($urandom_range(3) == 0) ? 0 : $urandom_range(9, 1);
      put32(tag_word);
      put32(body);
      repeat (body) put8(8'($urandom));
    end
    put32(IdData);
    case ($urandom_range(3))
      0:       put32(32'd0);
      1:       put32(32'hFFFF_FFFF);
      default: put32($urandom);
    endcase
    // trailing bytes after the data size are ignored by the parser
    if ($urandom_range(1) == 1) repeat ($urandom_range(3, 1)) put8(8'($urandom));
  endtask

  task automatic random_file();
    int unsigned pick;
    int unsigned cut;
    int unsigned base;
    build_wav();
    pick = $urandom_range(99);
    if (pick < 55) begin
      if ($urandom_range(3) == 0) file_ends[file_ends.size() - 1] = 1'b1;
    end else if (pick < 80) begin
      // truncated: ends early, or is abandoned for the next file start
      cut = $urandom_range(file_bytes.size() - 1, 1);
      while (file_bytes.size() > cut) begin
        void'(file_bytes.pop_back());
        void'(file_ends.pop_back());
      end
      if (pick < 70) file_ends[cut - 1] = 1'b1;
    end else if (pick < 92) begin
      case ($urandom_range(2))
        0:       base = 0;
        1:       base = 8;
        default: base = 12;
      endcase
      file_bytes[base + $urandom_range(3)] ^= 8'($urandom_range(255, 1));
    end else begin
      file_bytes.delete();
      file_ends.delete();
      repeat ($urandom_range(12, 1)) begin
        put8(8'($urandom));
        file_ends[file_ends.size() - 1] = ($urandom_range(3) == 0);
      end
    end
    send_file(1'b1);
  endtask

  initial begin
    stage_t plan[4];
    int     base_bytes;
    plan = '{StageFree, StageSendIdle, StageRecvStall, StageBoth};
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'd0;
    in_ch.file_start = 1'b0;
    in_ch.stream_end = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // first file after reset without a file start, bad RIFF tag
    put32({8'h58, IdRiff[23:0]});
    send_file(1'b0);
    // ignored after a result, stream end included
    send_byte(8'hFF, 1'b0, 1'b1);
    // early end inside the file size
    put32(IdRiff);
    put8(8'h00);
    file_ends[4] = 1'b1;
    send_file(1'b1);
    // bad WAVE tag after an all-ones file size
    put32(IdRiff);
    put32(32'hFFFF_FFFF);
    put32(IdWave ^ 32'h0100_0000);
    send_file(1'b1);
    // file start and stream end on the same beat
    send_byte(8'h52, 1'b1, 1'b1);
    wait_drained();

    foreach (plan[p]) begin
      stage <= plan[p];
      base_bytes = bytes_sent;
      while (bytes_sent - base_bytes < 170) random_file();
      if (plan[p] == StageFree) begin
        // results back up while the sink holds off
        stage <= StageHold;
        repeat (8) begin
          put32({IdRiff[31:24] ^ 8'($urandom_range(255, 1)), IdRiff[23:0]});
          send_file(1'b1);
        end
        wait_drained();
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
